// ===== rtl/core/frm_pkg.sv =====
// Shared types and constants of the fragmenting message ring.
// Used by frm_seq and fragmenting_message_ring; depends on nothing.
package frm_pkg;

   // default geometry
   localparam int SLOT_COUNT_DEF = 64;
   localparam int SLOT_BYTES_DEF = 60;

   // reciprocal shift used to split a byte count into slots
   localparam int RECIP_SHIFT = 24;
   localparam int LEN_W       = 16;

   // request modes
   localparam logic [2:0] MODE_BEGIN  = 3'd0;
   localparam logic [2:0] MODE_WRITE  = 3'd1;
   localparam logic [2:0] MODE_READ   = 3'd2;
   localparam logic [2:0] MODE_POLL_W = 3'd3;
   localparam logic [2:0] MODE_POLL_R = 3'd4;

   // response status codes
   localparam logic [2:0] STAT_OK       = 3'd0;
   localparam logic [2:0] STAT_NO_SPACE = 3'd1;
   localparam logic [2:0] STAT_EMPTY    = 3'd2;
   localparam logic [2:0] STAT_NO_OPEN  = 3'd3;
   localparam logic [2:0] STAT_ZERO_LEN = 3'd4;

   // configuration register indexes
   localparam logic CSR_UPDATE_THRESHOLD = 1'b0;

   typedef enum logic [1:0] {
      ELEM_EMPTY,
      ELEM_DATA,
      ELEM_EOF
   } frm_elem_type;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_EXEC,
      S_BEGIN,
      S_RD_INFO,
      S_RD_BYTE,
      S_SCAN_RQ,
      S_SCAN_CK
   } frm_state_type;

   typedef struct packed {
      logic [2:0] status;
      logic [7:0] data_out;
      logic       end_of_message;
      logic       event_fired;
      logic [5:0] free_slots;
   } frm_result_type;

endpackage

// ===== rtl/core/frm_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module frm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/frm_seq.sv =====
// Item sequencer of the message ring: ring pointers, slot state updates
// through the slot info RAM, byte RAM access and the result register.
// Depends on frm_pkg.
module frm_seq #(
   parameter int SLOT_COUNT = frm_pkg::SLOT_COUNT_DEF,
   parameter int SLOT_BYTES = frm_pkg::SLOT_BYTES_DEF,
   localparam int SI = $clog2(SLOT_COUNT),
   localparam int LW = $clog2(SLOT_BYTES + 1),
   localparam int IW = 2 + 2 * LW,
   localparam int BA = $clog2(SLOT_COUNT * SLOT_BYTES)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [6:0]            update_threshold,
   // request word
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [2:0]            req_mode,
   input  logic [7:0]            req_data,
   input  logic [15:0]           req_length,
   input  logic                  req_edge,
   // response word
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output frm_pkg::frm_result_type rsp_result,
   // slot info RAM
   output logic                  info_wr_en,
   output logic [SI-1:0]         info_wr_addr,
   output logic [IW-1:0]         info_wr_data,
   output logic                  info_rd_en,
   output logic [SI-1:0]         info_rd_addr,
   input  logic [IW-1:0]         info_rd_data,
   // byte RAM
   output logic                  byte_wr_en,
   output logic [BA-1:0]         byte_wr_addr,
   output logic [7:0]            byte_wr_data,
   output logic                  byte_rd_en,
   output logic [BA-1:0]         byte_rd_addr,
   input  logic [7:0]            byte_rd_data
);

   localparam int NW     = frm_pkg::LEN_W + 1;
   localparam int RECIP  = (2 ** frm_pkg::RECIP_SHIFT + SLOT_BYTES - 1) / SLOT_BYTES;
   localparam int RW     = frm_pkg::RECIP_SHIFT + 1;
   localparam int PW     = NW + RW;
   localparam logic [SI-1:0] LAST_SLOT = SI'(SLOT_COUNT - 1);
   localparam logic [LW-1:0] SB_L      = LW'(SLOT_BYTES);

   // add modulo the slot count; both operands stay below it
   function automatic logic [SI-1:0] wrap_add(input logic [SI-1:0] a,
                                              input logic [SI-1:0] b);
      logic [SI:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s >= (SI+1)'(SLOT_COUNT)) begin
         s = s - (SI+1)'(SLOT_COUNT);
      end
      return s[SI-1:0];
   endfunction

   // free slots between producer head and consumer tail, one kept unused
   function automatic logic [SI-1:0] free_between(input logic [SI-1:0] head,
                                                  input logic [SI-1:0] tail);
      logic [SI:0] d;
      d = {1'b0, tail} + (SI+1)'(SLOT_COUNT) - {1'b0, head} - (SI+1)'(1);
      if (d >= (SI+1)'(SLOT_COUNT)) begin
         d = d - (SI+1)'(SLOT_COUNT);
      end
      return d[SI-1:0];
   endfunction

   frm_pkg::frm_state_type state_ff, state_in;
   logic [2:0]   mode_ff, mode_in;
   logic [7:0]   din_ff, din_in;
   logic [15:0]  mlen_ff, mlen_in;
   logic         edge_ff, edge_in;
   logic [SI-1:0] reserve_ff, reserve_in;
   logic [SI-1:0] commit_ff, commit_in;
   logic [SI-1:0] wslot_ff, wslot_in;
   logic [LW-1:0] fill_ff, fill_in;
   logic [15:0]  left_ff, left_in;
   logic [SI-1:0] consume_ff, consume_in;
   logic [6:0]   freed_ff, freed_in;
   logic [SI-1:0] ptail_ff, ptail_in;
   logic [SI-1:0] lastfree_ff, lastfree_in;
   logic [SI-1:0] revpos_ff, revpos_in;
   logic [SI-1:0] pos_ff, pos_in;
   logic [SI-1:0] cnt_ff, cnt_in;
   logic [PW-1:0] prod_ff, prod_in;
   frm_pkg::frm_elem_type st_ff, st_in;
   logic [LW-1:0] len_ff, len_in;
   logic [LW-1:0] off_ff, off_in;
   logic         rdflag_ff, rdflag_in;
   logic         rsp_valid_ff, rsp_valid_in;
   frm_pkg::frm_result_type rsp_ff, rsp_in;

   logic         out_free;
   logic         respond;
   frm_pkg::frm_result_type res;
   logic [NW-1:0] len_round;
   logic [NW-1:0] need;
   logic [SI-1:0] free_res;
   logic [SI-1:0] free_cmt;
   logic [SI-1:0] fs_after;
   frm_pkg::frm_elem_type rd_st;
   logic [LW-1:0] rd_len;
   logic [LW-1:0] rd_off;
   logic [LW-1:0] fill_next;
   logic [15:0]  left_next;
   logic [LW-1:0] off_next;
   logic [6:0]   freed_next;
   logic [SI-1:0] consume_next;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign len_round = {1'b0, mlen_ff} + NW'(SLOT_BYTES - 1);
   assign need      = prod_ff[frm_pkg::RECIP_SHIFT +: NW];
   assign free_res  = free_between(reserve_ff, ptail_ff);
   assign free_cmt  = free_between(commit_ff, ptail_ff);
   assign rd_st     = frm_pkg::frm_elem_type'(info_rd_data[IW-1 -: 2]);
   assign rd_len    = info_rd_data[2*LW-1 -: LW];
   assign rd_off    = info_rd_data[LW-1:0];
   assign fill_next = fill_ff + LW'(1);
   assign left_next = left_ff - 16'd1;
   assign off_next  = rdflag_ff ? off_ff + LW'(1) : off_ff;
   assign freed_next   = freed_ff + 7'd1;
   assign consume_next = wrap_add(consume_ff, SI'(1));
   assign fs_after  = free_between(reserve_in, ptail_in);

   // next state, RAM control and result
   always_comb begin
      state_in    = state_ff;
      mode_in     = mode_ff;
      din_in      = din_ff;
      mlen_in     = mlen_ff;
      edge_in     = edge_ff;
      reserve_in  = reserve_ff;
      commit_in   = commit_ff;
      wslot_in    = wslot_ff;
      fill_in     = fill_ff;
      left_in     = left_ff;
      consume_in  = consume_ff;
      freed_in    = freed_ff;
      ptail_in    = ptail_ff;
      lastfree_in = lastfree_ff;
      revpos_in   = revpos_ff;
      pos_in      = pos_ff;
      cnt_in      = cnt_ff;
      prod_in     = prod_ff;
      st_in       = st_ff;
      len_in      = len_ff;
      off_in      = off_ff;
      rdflag_in   = rdflag_ff;
      respond     = 1'b0;
      res         = '0;
      req_ready   = 1'b0;
      info_wr_en   = 1'b0;
      info_wr_addr = consume_ff;
      info_wr_data = '0;
      info_rd_en   = 1'b0;
      info_rd_addr = consume_ff;
      byte_wr_en   = 1'b0;
      byte_wr_addr = BA'(wslot_ff * SLOT_BYTES) + BA'(fill_ff);
      byte_wr_data = din_ff;
      byte_rd_en   = 1'b0;
      byte_rd_addr = BA'(consume_ff * SLOT_BYTES) + BA'(rd_off);

      case (state_ff)
         frm_pkg::S_CLEAR: begin
            // sweep the slot info RAM to empty
            info_wr_en   = 1'b1;
            info_wr_addr = pos_ff;
            info_wr_data = '0;
            pos_in       = pos_ff + SI'(1);
            if (pos_ff == LAST_SLOT) begin
               pos_in   = '0;
               state_in = frm_pkg::S_IDLE;
            end
         end
         frm_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               mode_in  = req_mode;
               din_in   = req_data;
               mlen_in  = req_length;
               edge_in  = req_edge;
               state_in = frm_pkg::S_EXEC;
            end
         end
         frm_pkg::S_EXEC: begin
            case (mode_ff)
               frm_pkg::MODE_BEGIN: begin
                  if (mlen_ff == 16'd0) begin
                     res.status = frm_pkg::STAT_ZERO_LEN;
                     respond    = out_free;
                  end else begin
                     prod_in  = PW'(len_round) * PW'(RECIP);
                     state_in = frm_pkg::S_BEGIN;
                  end
               end
               frm_pkg::MODE_WRITE: begin
                  if (left_ff == 16'd0) begin
                     res.status = frm_pkg::STAT_NO_OPEN;
                     respond    = out_free;
                  end else if (out_free) begin
                     // append byte, close the slot when full or last
                     respond    = 1'b1;
                     byte_wr_en = 1'b1;
                     fill_in    = fill_next;
                     left_in    = left_next;
                     if (fill_next >= SB_L || left_next == 16'd0) begin
                        info_wr_en   = 1'b1;
                        info_wr_addr = wslot_ff;
                        info_wr_data = {(left_next == 16'd0) ? frm_pkg::ELEM_EOF
                                                             : frm_pkg::ELEM_DATA,
                                        fill_next, LW'(0)};
                        wslot_in = wrap_add(wslot_ff, SI'(1));
                        fill_in  = '0;
                        if (left_next == 16'd0) begin
                           commit_in = reserve_ff;
                        end
                     end
                  end
               end
               frm_pkg::MODE_READ: begin
                  info_rd_en   = 1'b1;
                  info_rd_addr = consume_ff;
                  state_in     = frm_pkg::S_RD_INFO;
               end
               frm_pkg::MODE_POLL_W: begin
                  res.event_fired = edge_ff ? (free_cmt > lastfree_ff)
                                            : (free_cmt != '0);
                  if (out_free) begin
                     respond     = 1'b1;
                     lastfree_in = free_cmt;
                  end
               end
               frm_pkg::MODE_POLL_R: begin
                  pos_in   = edge_ff ? revpos_ff : consume_ff;
                  cnt_in   = '0;
                  state_in = frm_pkg::S_SCAN_RQ;
               end
               default: begin
                  respond = out_free;
               end
            endcase
         end
         frm_pkg::S_BEGIN: begin
            // reserve the slots if no message is open and the producer sees room
            if (left_ff != 16'd0 || need > NW'(free_res)) begin
               res.status = frm_pkg::STAT_NO_SPACE;
               respond    = out_free;
            end else if (out_free) begin
               respond    = 1'b1;
               wslot_in   = reserve_ff;
               reserve_in = wrap_add(reserve_ff, need[SI-1:0]);
               fill_in    = '0;
               left_in    = mlen_ff;
            end
         end
         frm_pkg::S_RD_INFO: begin
            st_in  = rd_st;
            len_in = rd_len;
            off_in = rd_off;
            if (rd_st == frm_pkg::ELEM_EMPTY) begin
               res.status = frm_pkg::STAT_EMPTY;
               respond    = out_free;
            end else begin
               rdflag_in  = (rd_off < rd_len) && (rd_off < SB_L);
               byte_rd_en = (rd_off < rd_len) && (rd_off < SB_L);
               state_in   = frm_pkg::S_RD_BYTE;
            end
         end
         frm_pkg::S_RD_BYTE: begin
            res.data_out = rdflag_ff ? byte_rd_data : 8'd0;
            if (out_free) begin
               respond      = 1'b1;
               info_wr_en   = 1'b1;
               info_wr_addr = consume_ff;
               if (off_next >= len_ff) begin
                  // slot drained: free it and maybe publish the tail
                  res.end_of_message = (st_ff == frm_pkg::ELEM_EOF);
                  info_wr_data = {frm_pkg::ELEM_EMPTY, len_ff, LW'(0)};
                  consume_in   = consume_next;
                  if (freed_next >= update_threshold) begin
                     ptail_in = consume_next;
                     freed_in = '0;
                  end else begin
                     freed_in = freed_next;
                  end
               end else begin
                  info_wr_data = {st_ff, len_ff, off_next};
               end
            end
         end
         frm_pkg::S_SCAN_RQ: begin
            info_rd_en   = 1'b1;
            info_rd_addr = pos_ff;
            state_in     = frm_pkg::S_SCAN_CK;
         end
         frm_pkg::S_SCAN_CK: begin
            if (rd_st == frm_pkg::ELEM_EMPTY) begin
               respond = out_free;
            end else if (rd_st == frm_pkg::ELEM_EOF) begin
               res.event_fired = 1'b1;
               if (out_free) begin
                  respond = 1'b1;
                  if (edge_ff) begin
                     revpos_in = wrap_add(pos_ff, SI'(1));
                  end
               end
            end else if (cnt_ff == LAST_SLOT) begin
               respond = out_free;
            end else begin
               cnt_in   = cnt_ff + SI'(1);
               pos_in   = wrap_add(pos_ff, SI'(1));
               state_in = frm_pkg::S_SCAN_RQ;
            end
         end
         default: begin
            state_in = frm_pkg::S_IDLE;
         end
      endcase

      res.free_slots = (32'(fs_after) > 32'd63) ? 6'd63 : 6'(fs_after);

      // hold the result until taken
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      if (respond) begin
         rsp_valid_in = 1'b1;
         rsp_in       = res;
         state_in     = frm_pkg::S_IDLE;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= frm_pkg::S_CLEAR;
         reserve_ff   <= '0;
         commit_ff    <= '0;
         wslot_ff     <= '0;
         fill_ff      <= '0;
         left_ff      <= '0;
         consume_ff   <= '0;
         freed_ff     <= '0;
         ptail_ff     <= '0;
         lastfree_ff  <= '0;
         revpos_ff    <= '0;
         pos_ff       <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         reserve_ff   <= reserve_in;
         commit_ff    <= commit_in;
         wslot_ff     <= wslot_in;
         fill_ff      <= fill_in;
         left_ff      <= left_in;
         consume_ff   <= consume_in;
         freed_ff     <= freed_in;
         ptail_ff     <= ptail_in;
         lastfree_ff  <= lastfree_in;
         revpos_ff    <= revpos_in;
         pos_ff       <= pos_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      mode_ff   <= mode_in;
      din_ff    <= din_in;
      mlen_ff   <= mlen_in;
      edge_ff   <= edge_in;
      prod_ff   <= prod_in;
      st_ff     <= st_in;
      len_ff    <= len_in;
      off_ff    <= off_in;
      rdflag_ff <= rdflag_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_result = rsp_ff;

endmodule

// ===== rtl/core/fragmenting_message_ring.sv =====
// Message FIFO on a ring of SLOT_COUNT fixed slots of up to SLOT_BYTES bytes each. A begin word
// reserves ceil(length/SLOT_BYTES) slots, write words append bytes, read words drain them and
// return end_of_message on a message's last byte; polls report write and read readiness. Words
// are taken one at a time: a begin goes through the reciprocal multiply, a read through the slot
// info RAM and then the byte RAM reads, and a read poll scans at most SLOT_COUNT slots with one
// info RAM read per check. A result word held back by rsp_tready stalls the next result.
// After reset the slot info RAM is swept to empty before the first word is taken;
// update_threshold can be written over the csr port at any time.
// Depends on frm_pkg, frm_seq and frm_ram.
module fragmenting_message_ring #(
   parameter int SLOT_COUNT = frm_pkg::SLOT_COUNT_DEF,
   parameter int SLOT_BYTES = frm_pkg::SLOT_BYTES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // request stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // data_in[7:0], message_length[23:8], edge_triggered[24]
   input  logic [2:0]  req_tuser,   // mode[2:0]
   // result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // status[2:0], data_out[10:3], event_fired[11],
                                    // free_slots[17:12]
   output logic        rsp_tlast,   // end_of_message
   // configuration
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int SI = $clog2(SLOT_COUNT);
   localparam int LW = $clog2(SLOT_BYTES + 1);
   localparam int IW = 2 + 2 * LW;
   localparam int BA = $clog2(SLOT_COUNT * SLOT_BYTES);

   logic [6:0] thr_ff, thr_in;
   logic       csr_hit;
   frm_pkg::frm_result_type result;

   logic          info_wr_en, info_rd_en, byte_wr_en, byte_rd_en;
   logic [SI-1:0] info_wr_addr, info_rd_addr;
   logic [IW-1:0] info_wr_data, info_rd_data;
   logic [BA-1:0] byte_wr_addr, byte_rd_addr;
   logic [7:0]    byte_wr_data, byte_rd_data;

   // register decode
   assign csr_hit    = (csr_paddr[1:0] == 2'b00) &&
                       (csr_paddr[2] == frm_pkg::CSR_UPDATE_THRESHOLD);
   assign csr_pready = 1'b1;
   assign csr_prdata = csr_hit ? {25'd0, thr_ff} : 32'd0;

   always_comb begin
      thr_in = thr_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_hit) begin
         thr_in = csr_pwdata[6:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= 7'd1;
      end else begin
         thr_ff <= thr_in;
      end
   end

   frm_seq #(
      .SLOT_COUNT (SLOT_COUNT),
      .SLOT_BYTES (SLOT_BYTES)
   ) u_seq (
      .clock            (clock),
      .reset            (reset),
      .update_threshold (thr_ff),
      .req_valid        (req_tvalid),
      .req_ready        (req_tready),
      .req_mode         (req_tuser),
      .req_data         (req_tdata[7:0]),
      .req_length       (req_tdata[23:8]),
      .req_edge         (req_tdata[24]),
      .rsp_valid        (rsp_tvalid),
      .rsp_ready        (rsp_tready),
      .rsp_result       (result),
      .info_wr_en       (info_wr_en),
      .info_wr_addr     (info_wr_addr),
      .info_wr_data     (info_wr_data),
      .info_rd_en       (info_rd_en),
      .info_rd_addr     (info_rd_addr),
      .info_rd_data     (info_rd_data),
      .byte_wr_en       (byte_wr_en),
      .byte_wr_addr     (byte_wr_addr),
      .byte_wr_data     (byte_wr_data),
      .byte_rd_en       (byte_rd_en),
      .byte_rd_addr     (byte_rd_addr),
      .byte_rd_data     (byte_rd_data)
   );

   // slot state, length and read offset
   frm_ram #(
      .WIDTH (IW),
      .DEPTH (SLOT_COUNT)
   ) u_info_ram (
      .clock   (clock),
      .wr_en   (info_wr_en),
      .wr_addr (info_wr_addr),
      .wr_data (info_wr_data),
      .rd_en   (info_rd_en),
      .rd_addr (info_rd_addr),
      .rd_data (info_rd_data)
   );

   // fragment bytes
   frm_ram #(
      .WIDTH (8),
      .DEPTH (SLOT_COUNT * SLOT_BYTES)
   ) u_byte_ram (
      .clock   (clock),
      .wr_en   (byte_wr_en),
      .wr_addr (byte_wr_addr),
      .wr_data (byte_wr_data),
      .rd_en   (byte_rd_en),
      .rd_addr (byte_rd_addr),
      .rd_data (byte_rd_data)
   );

   assign rsp_tdata = {6'd0, result.free_slots, result.event_fired,
                       result.data_out, result.status};
   assign rsp_tlast = result.end_of_message;

endmodule
